FILE: rtl/core/allele_count_top_two_caller_core_macros.svh
// ----------------------------------------------------------------------------
// allele count caller assertion macros
// shared property forms for the checker, clocked on aclk, reset by aresetn
// ----------------------------------------------------------------------------
`ifndef ALLELE_COUNT_TOP_TWO_CALLER_CORE_MACROS_SVH
`define ALLELE_COUNT_TOP_TWO_CALLER_CORE_MACROS_SVH

// same-cycle implication
`define ACTC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("actc assertion failed");

// next-cycle implication
`define ACTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("actc assertion failed");

`endif

FILE: rtl/core/actc_pkg.sv
// ----------------------------------------------------------------------------
// actc_pkg
// types and constants shared by the allele count caller modules
// ----------------------------------------------------------------------------
package actc_pkg;

    localparam int COUNT_BITS = 24;
    localparam int WIDE_BITS  = COUNT_BITS + 4;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [WIDE_BITS-1:0]  wide_t;
    typedef logic [2:0]            code_t;
    typedef logic [7:0]            char_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam char_t CHAR_COLON = 8'h3A;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;

    localparam code_t CODE_A = 3'd0;
    localparam code_t CODE_N = 3'd4;
    localparam code_t CODE_D = 3'd5;

    // slots below this take a count on a colon
    localparam logic [2:0] LAST_COLON_SLOT = 3'd5;

    typedef struct packed {
        char_t text_char;
        logic  field_end;
    } item_t;

    typedef struct packed {
        code_t major_code;
        code_t minor_code;
        logic  no_data;
        logic  single_allele;
    } result_t;

endpackage

FILE: rtl/core/actc_in_stage.sv
// ----------------------------------------------------------------------------
// actc_in_stage
// input register: holds one character beat until the tally can take it
// ----------------------------------------------------------------------------
module actc_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  actc_pkg::item_t s_item,
    input  logic           out_busy,
    output logic           advance,
    output actc_pkg::item_t item
);
    import actc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // a beat that ends a field needs room in the result register
    assign advance = valid_reg && (!item_reg.field_end || !out_busy);
    assign s_ready = !valid_reg || advance;
    assign item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: rtl/core/actc_tally.sv
// ----------------------------------------------------------------------------
// actc_tally
// decimal count accumulator and running top-two ranking of allele counts
// ----------------------------------------------------------------------------
module actc_tally (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  actc_pkg::item_t   item,
    output actc_pkg::result_t result
);
    import actc_pkg::*;

    logic [2:0] slot_reg,   slot_next;
    count_t     acc_reg,    acc_next;
    count_t     best_reg,   best_next;
    count_t     runner_reg, runner_next;
    code_t      bcode_reg,  bcode_next;
    code_t      rcode_reg,  rcode_next;
    logic [1:0] seen_reg,   seen_next;

    logic    is_digit;
    logic    is_colon;
    wide_t   acc_wide;
    count_t  acc_upd;
    logic    offer_on;
    code_t   offer_code;
    count_t  offer_val;
    result_t res;

    always_comb begin
        is_digit = item.text_char inside {[CHAR_ZERO:CHAR_NINE]};
        is_colon = (item.text_char == CHAR_COLON);

        // acc * 10 + digit, saturating
        acc_wide = (wide_t'(acc_reg) << 3) + (wide_t'(acc_reg) << 1)
                 + wide_t'(item.text_char[3:0]);
        if (is_digit) begin
            acc_upd = (acc_wide[WIDE_BITS-1:COUNT_BITS] != '0) ? COUNT_MAX
                                                                : acc_wide[COUNT_BITS-1:0];
        end else if (is_colon) begin
            acc_upd = '0;
        end else begin
            acc_upd = acc_reg;
        end

        slot_next = slot_reg;
        if (is_colon && slot_reg < LAST_COLON_SLOT) begin
            slot_next = slot_reg + 3'd1;
        end

        // at most one nonzero count completes per beat: a colon closes its
        // slot, and the trailing count after a final colon is empty
        offer_on   = 1'b0;
        offer_code = CODE_D;
        offer_val  = '0;
        if (is_colon && slot_reg < LAST_COLON_SLOT) begin
            offer_on   = 1'b1;
            offer_code = slot_reg;
            offer_val  = acc_reg;
        end else if (item.field_end) begin
            offer_on   = 1'b1;
            offer_code = CODE_D;
            offer_val  = acc_upd;
        end

        best_next   = best_reg;
        runner_next = runner_reg;
        bcode_next  = bcode_reg;
        rcode_next  = rcode_reg;
        seen_next   = seen_reg;
        if (offer_on && offer_val != '0) begin
            if (seen_reg == 2'd0) begin
                best_next  = offer_val;
                bcode_next = offer_code;
            end else if (offer_val > best_reg) begin
                // displaced major drops to minor
                runner_next = best_reg;
                rcode_next  = bcode_reg;
                best_next   = offer_val;
                bcode_next  = offer_code;
            end else if (seen_reg == 2'd1 || offer_val > runner_reg) begin
                runner_next = offer_val;
                rcode_next  = offer_code;
            end
            if (seen_reg != 2'd2) begin
                seen_next = seen_reg + 2'd1;
            end
        end

        case (seen_next)
            2'd0: begin
                res.major_code    = CODE_N;
                res.minor_code    = CODE_N;
                res.no_data       = 1'b1;
                res.single_allele = 1'b0;
            end
            2'd1: begin
                res.major_code    = bcode_next;
                res.minor_code    = bcode_next;
                res.no_data       = 1'b0;
                res.single_allele = 1'b1;
            end
            default: begin
                res.major_code    = bcode_next;
                res.minor_code    = rcode_next;
                res.no_data       = 1'b0;
                res.single_allele = 1'b0;
            end
        endcase

        acc_next = acc_upd;
        // field done: start clean for the next one
        if (item.field_end) begin
            slot_next   = '0;
            acc_next    = '0;
            best_next   = '0;
            runner_next = '0;
            bcode_next  = CODE_A;
            rcode_next  = CODE_A;
            seen_next   = '0;
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            acc_reg    <= '0;
            best_reg   <= '0;
            runner_reg <= '0;
            bcode_reg  <= CODE_A;
            rcode_reg  <= CODE_A;
            seen_reg   <= '0;
        end else if (advance) begin
            slot_reg   <= slot_next;
            acc_reg    <= acc_next;
            best_reg   <= best_next;
            runner_reg <= runner_next;
            bcode_reg  <= bcode_next;
            rcode_reg  <= rcode_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

FILE: rtl/core/actc_out_stage.sv
// ----------------------------------------------------------------------------
// actc_out_stage
// result register: holds one call until the downstream side takes the beat
// ----------------------------------------------------------------------------
module actc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  actc_pkg::result_t result,
    output logic              out_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output actc_pkg::result_t m_result
);
    import actc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_busy = valid_reg && !m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

FILE: rtl/core/allele_count_top_two_caller_core.sv
// ----------------------------------------------------------------------------
// allele_count_top_two_caller_core
// major/minor allele caller over one A:T:C:G:N:D count field
// ----------------------------------------------------------------------------
// Takes one character per beat and sustains one beat per clock. An accepted
// beat lands in the input register, and the tally then folds it into the
// count accumulator and top-two ranking as it leaves that register; the beat
// that ends a field writes its call into the result register as it leaves,
// and m_valid is driven from that result register. The input side stalls
// only when a field end meets a result that has not yet been taken.
module allele_count_top_two_caller_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  actc_pkg::char_t      s_text_char,
    input  logic                 s_field_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output actc_pkg::code_t      m_major_code,
    output actc_pkg::code_t      m_minor_code,
    output logic                 m_no_data,
    output logic                 m_single_allele
);
    import actc_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    advance;
    logic    out_busy;
    result_t result;
    result_t m_result;

    assign s_item.text_char = s_text_char;
    assign s_item.field_end = s_field_end;

    actc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_busy (out_busy),
        .advance  (advance),
        .item     (item)
    );

    actc_tally u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    actc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item.field_end),
        .result   (result),
        .out_busy (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_major_code    = m_result.major_code;
    assign m_minor_code    = m_result.minor_code;
    assign m_no_data       = m_result.no_data;
    assign m_single_allele = m_result.single_allele;

endmodule

FILE: rtl/core/actc_checker.sv
// ----------------------------------------------------------------------------
// actc_checker
// port-level checks on the allele caller, bound to the top level
// ----------------------------------------------------------------------------
`include "allele_count_top_two_caller_core_macros.svh"

module actc_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input actc_pkg::char_t s_text_char,
    input logic            s_field_end,
    input logic            m_valid,
    input logic            m_ready,
    input actc_pkg::code_t m_major_code,
    input actc_pkg::code_t m_minor_code,
    input logic            m_no_data,
    input logic            m_single_allele
);
    import actc_pkg::*;

    // a stalled result beat holds
    `ACTC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_major_code) && $stable(m_minor_code) && $stable(m_no_data) && $stable(m_single_allele))

    // an empty field reports N for both codes and is not single-allele
    `ACTC_ASSERT_NOW(a_no_data, m_valid && m_no_data, m_major_code == CODE_N && m_minor_code == CODE_N && !m_single_allele)

    // a single-allele call repeats the major as minor
    `ACTC_ASSERT_NOW(a_single, m_valid && m_single_allele, m_minor_code == m_major_code)

    // two distinct alleles never share a code, and codes stay in range
    `ACTC_ASSERT_NOW(a_codes, m_valid && !m_no_data && !m_single_allele, m_minor_code != m_major_code && m_major_code <= CODE_D && m_minor_code <= CODE_D)

endmodule

bind allele_count_top_two_caller_core actc_checker u_actc_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the allele count caller against a cycle-free model of its calls
// ----------------------------------------------------------------------------
// Text beats go in one character at a time. Each accepted beat updates a
// local tally of the six counts and the top-two ranking. Each field end
// queues the call it should produce. Calls taken from the result port are
// compared field by field with the oldest queued call. Directed fields come
// first, then random fields with stray characters, broken separators and
// large counts, under random idling on both sides and a quiet tail.
module tb_top;
    import actc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BUSY_BEATS   = 1000;
    localparam int TOTAL_BEATS  = 1200;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    char_t  s_text_char;
    logic   s_field_end;
    logic   m_valid;
    logic   m_ready;
    code_t  m_major_code;
    code_t  m_minor_code;
    logic   m_no_data;
    logic   m_single_allele;

    allele_count_top_two_caller_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_char     (s_text_char),
        .s_field_end     (s_field_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_major_code    (m_major_code),
        .m_minor_code    (m_minor_code),
        .m_no_data       (m_no_data),
        .m_single_allele (m_single_allele)
    );

    // local copy of the tally
    logic [2:0] slot;
    count_t     acc;
    count_t     best_cnt;
    count_t     runner_cnt;
    code_t      best_cd;
    code_t      runner_cd;
    logic [1:0] seen;

    result_t    expected_calls[$];
    result_t    want;
    int         mismatches;
    int         beats_counted;
    int         cycle_count;
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         noise_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_tally();
        slot       = '0;
        acc        = '0;
        best_cnt   = '0;
        runner_cnt = '0;
        best_cd    = CODE_A;
        runner_cd  = CODE_A;
        seen       = '0;
    endfunction

    function automatic void rank_allele(code_t cd, count_t v);
        if (v == '0) return;
        if (seen == 2'd0) begin
            best_cnt = v;
            best_cd  = cd;
        end else if (v > best_cnt) begin
            // old major drops to minor
            runner_cnt = best_cnt;
            runner_cd  = best_cd;
            best_cnt   = v;
            best_cd    = cd;
        end else if (seen == 2'd1 || v > runner_cnt) begin
            runner_cnt = v;
            runner_cd  = cd;
        end
        if (seen < 2'd2) seen = seen + 2'd1;
    endfunction

    function automatic void tally_char(char_t c, logic fe);
        logic [35:0] nxt;
        result_t     call;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            nxt = 36'(acc) * 36'd10 + 36'(c - CHAR_ZERO);
            acc = (nxt > 36'(COUNT_MAX)) ? COUNT_MAX : nxt[COUNT_BITS-1:0];
        end else if (c == CHAR_COLON) begin
            if (slot < LAST_COLON_SLOT) begin
                rank_allele(slot, acc);
                slot = slot + 3'd1;
            end
            acc = '0;
        end
        if (!fe) return;
        rank_allele(CODE_D, acc);
        if (seen == 2'd0) begin
            call.major_code    = CODE_N;
            call.minor_code    = CODE_N;
            call.no_data       = 1'b1;
            call.single_allele = 1'b0;
        end else begin
            call.major_code    = best_cd;
            call.minor_code    = (seen == 2'd1) ? best_cd : runner_cd;
            call.no_data       = 1'b0;
            call.single_allele = (seen == 2'd1);
        end
        expected_calls.insert(expected_calls.size(), call);
        clear_tally();
    endfunction

    function automatic void check_field(string field, logic [2:0] want_v, logic [2:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_calls.size() == 0) begin
                $display("%0t: call with no field pending, got major %0d minor %0d",
                         $time, m_major_code, m_minor_code);
                mismatches++;
            end else begin
                want = expected_calls.pop_front();
                check_field("major_code", want.major_code, m_major_code);
                check_field("minor_code", want.minor_code, m_minor_code);
                check_field("no_data", 3'(want.no_data), 3'(m_no_data));
                check_field("single_allele", 3'(want.single_allele), 3'(m_single_allele));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: m_ready drops low in random stall bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input char_t c, input logic fe);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_text_char <= c;
        s_field_end <= fe;
        do @(posedge aclk); while (!s_ready);
        tally_char(c, fe);
        if ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON || fe) beats_counted++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_calls.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic char_t random_noise();
        char_t c;
        do c = char_t'($urandom_range(0, 255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON);
        return c;
    endfunction

    function automatic string random_count_text();
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0:             return "";
            1:             return "0";
            2:             return "000";
            3, 4, 5, 6, 7: return $sformatf("%0d", $urandom_range(1, 6));
            8, 9, 10:      return $sformatf("%0d", $urandom_range(7, 999));
            11:            return $sformatf("0%0d", $urandom_range(1, 99));
            12:            return $sformatf("%0d", $urandom_range(1000, 20000000));
            // right around the count ceiling
            13:            return $sformatf("%0d", int'(COUNT_MAX) - $urandom_range(0, 2));
            14:            return $sformatf("%0d", int'(COUNT_MAX) + $urandom_range(1, 3));
            default:       return $sformatf("%0d", $urandom());
        endcase
    endfunction

    task automatic send_field_text(input string txt, input bit stray_end);
        for (int i = 0; i < txt.len(); i++) begin
            if (noise_on && $urandom_range(0, 24) == 0) send_beat(random_noise(), 1'b0);
            send_beat(txt[i], !stray_end && i == txt.len() - 1);
        end
        if (stray_end || txt.len() == 0) send_beat(random_noise(), 1'b1);
    endtask

    task automatic random_field();
        string txt;
        int    shape;
        int    n_counts;
        int    solo;
        shape = $urandom_range(0, 19);
        // mostly six counts, now and then too few or too many separators
        if (shape == 0)      n_counts = $urandom_range(1, 5);
        else if (shape == 1) n_counts = $urandom_range(7, 9);
        else                 n_counts = 6;
        solo = $urandom_range(0, n_counts - 1);
        txt  = "";
        for (int i = 0; i < n_counts; i++) begin
            if (i > 0) txt = {txt, ":"};
            if (shape == 4 || (shape == 5 && i != solo)) txt = {txt, "0"};
            else                                         txt = {txt, random_count_text()};
        end
        if (shape == 2) txt = {txt, ":"};
        send_field_text(txt, shape == 3);
    endtask

    task automatic test_no_data();
        send_beat(8'hFF, 1'b1);
        send_field_text("0:0", 1'b0);
    endtask

    task automatic test_ranking();
        send_field_text("1:2:3", 1'b0);
        send_field_text("3:3", 1'b0);
        send_field_text("4:", 1'b0);
    endtask

    task automatic test_extra_separators();
        send_beat("1", 1'b0);
        send_beat(8'h00, 1'b0);
        send_field_text(":::::7:2", 1'b0);
    endtask

    task automatic test_overflow();
        send_field_text("99999999", 1'b0);
    endtask

    task automatic test_random_busy();
        bit drained;
        drained  = 1'b0;
        noise_on = 1'b1;
        while (beats_counted < BUSY_BEATS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            random_field();
            // one full drain midway through
            if (!drained && beats_counted >= BUSY_BEATS / 2) begin
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    task automatic test_random_quiet();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (beats_counted < TOTAL_BEATS) random_field();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_char = '0;
        s_field_end = 1'b0;
        mismatches    = 0;
        beats_counted = 0;
        cycle_count   = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        noise_on      = 1'b0;
        clear_tally();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_no_data();
        test_ranking();
        test_extra_separators();
        test_overflow();
        test_random_busy();
        test_random_quiet();
        wait_drained();

        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
